// ===== rtl/axr3d_pkg.sv =====
// axr3d_pkg: widths, constants, types and helpers of the 3d axis rotation unit
// used by axis_rotation_3d_unit, depends on nothing
package axr3d_pkg;

    // field widths
    localparam int COORD_WIDTH = 32;
    localparam int ANGLE_WIDTH = 32;
    localparam int MODE_W      = 2;

    // stream word widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((ANGLE_WIDTH + 3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

    // internal binary angle: 2^BAM_WIDTH per turn
    localparam int BAM_WIDTH = 32;
    localparam int ITERS     = 32;
    localparam int GUARD     = 8;

    // inverse cordic gain in q0.32
    localparam int                    GAIN_WIDTH  = 32;
    localparam logic [GAIN_WIDTH-1:0] INV_GAIN    = 32'h9B74EDA8;
    localparam int                    PROD_W      = COORD_WIDTH + GAIN_WIDTH;
    localparam int                    SCALE_SHIFT = GAIN_WIDTH - GUARD;
    localparam int                    SCL_W       = PROD_W - SCALE_SHIFT;
    localparam logic [PROD_W-1:0]     SCL_RND     = PROD_W'(1) << (SCALE_SHIFT - 1);

    // cordic datapath: guard bits plus two bits of headroom for the sqrt(2) growth
    localparam int CORD_W = COORD_WIDTH + GUARD + 2;
    localparam int ZW     = BAM_WIDTH + 2;
    localparam int RW     = CORD_W - GUARD;

    localparam logic signed [CORD_W-1:0]      OUT_RND   = CORD_W'(1) << (GUARD - 1);
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX =
        signed'({1'b0, {(COORD_WIDTH - 1){1'b1}}});
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN =
        signed'({1'b1, {(COORD_WIDTH - 1){1'b0}}});
    localparam logic signed [RW-1:0]          RES_MAX   = RW'(COORD_MAX);
    localparam logic signed [RW-1:0]          RES_MIN   = RW'(COORD_MIN);

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [BAM_WIDTH-1:0] ATAN_TAB [ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [MODE_W-1:0] {
        MODE_X    = 2'd0,
        MODE_Y    = 2'd1,
        MODE_Z    = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    // what travels beside the cordic pair
    typedef struct packed {
        t_mode                          mode;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } t_side;

    typedef struct packed {
        logic                           clip;
        logic signed [COORD_WIDTH-1:0] val;
    } t_sat;

    // round half up out of the guard bits, then clip to the coordinate range
    function automatic t_sat sat_coord(input logic signed [CORD_W-1:0] w);
        logic signed [CORD_W-1:0] sum;
        logic signed [RW-1:0]     r;
        t_sat                     res;
        sum = w + OUT_RND;
        r   = signed'(sum[CORD_W-1:GUARD]);
        if (r > RES_MAX) begin
            res.clip = 1'b1;
            res.val  = COORD_MAX;
        end else if (r < RES_MIN) begin
            res.clip = 1'b1;
            res.val  = COORD_MIN;
        end else begin
            res.clip = 1'b0;
            res.val  = COORD_WIDTH'(r);
        end
        return res;
    endfunction

endpackage

// ===== rtl/axis_rotation_3d_unit.sv =====
// axis_rotation_3d_unit: rotates a point about the x, y or z axis with a pipelined cordic
// depends on axr3d_pkg for widths, the arctangent table and the saturation helper
//
// path: input, product, rounding and cordic head registers, cordic stages, output register
// throughput: one word per cycle unless stalled, one cordic micro-rotation per stage
// stalls freeze the whole pipeline only while the output register is full and not taken
// and the last cordic stage holds a word; bubbles in front of a full output drain
// reset: synchronous active-low i_rst_n clears the valid bits only, no clearing pass
module axis_rotation_3d_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave side
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata fields from bit 0: angle, x_in, y_in, z_in
    input  logic [axr3d_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser fields from bit 0: mode
    input  logic [axr3d_pkg::MODE_W-1:0]         s_axis_tuser,
    // master side
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata fields from bit 0: x_out, y_out, z_out
    output logic [axr3d_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser fields from bit 0: saturated
    output logic [0:0]                           m_axis_tuser
);

    localparam int CW    = axr3d_pkg::COORD_WIDTH;
    localparam int AW    = axr3d_pkg::ANGLE_WIDTH;
    localparam int BW    = axr3d_pkg::BAM_WIDTH;
    localparam int NI    = axr3d_pkg::ITERS;
    localparam int PW    = axr3d_pkg::PROD_W;
    localparam int SW    = axr3d_pkg::SCL_W;
    localparam int DW    = axr3d_pkg::CORD_W;
    localparam int ZW    = axr3d_pkg::ZW;
    localparam int SSH   = axr3d_pkg::SCALE_SHIFT;

    // ------------------------------------------------------------------
    // flow control
    // the output register loads when empty or taken; the pipeline moves
    // when the output register loads or the word in front of it is a bubble
    // ------------------------------------------------------------------
    logic w_out_load;
    logic w_adv;
    logic r_out_vld;
    logic r_cvld [0:NI];

    assign w_out_load    = m_axis_tready || !r_out_vld;
    assign w_adv         = w_out_load || !r_cvld[NI];
    assign s_axis_tready = w_adv;

    // ------------------------------------------------------------------
    // input decode: pick the rotated pair, fold the angle into +-90 deg
    // ------------------------------------------------------------------
    axr3d_pkg::t_mode          w_mode;
    logic [AW-1:0]             w_angle;
    logic signed [CW-1:0]      w_x;
    logic signed [CW-1:0]      w_y;
    logic signed [CW-1:0]      w_z;
    logic [BW-1:0]             w_bam;
    logic                      w_fold;
    logic [BW-1:0]             w_bam_f;
    logic signed [CW-1:0]      w_u;
    logic signed [CW-1:0]      w_v;
    logic [CW-1:0]             w_mag_u;
    logic [CW-1:0]             w_mag_v;

    assign w_mode  = axr3d_pkg::t_mode'(s_axis_tuser);
    assign w_angle = s_axis_tdata[AW-1:0];
    assign w_x     = signed'(s_axis_tdata[AW +: CW]);
    assign w_y     = signed'(s_axis_tdata[AW + CW +: CW]);
    assign w_z     = signed'(s_axis_tdata[AW + 2 * CW +: CW]);

    // narrow angles sit in the top bits of the internal binary angle
    assign w_bam   = BW'(w_angle) << (BW - AW);
    // beyond +-90 deg: rotate by 180 deg first, an exact negation of the pair
    assign w_fold  = w_bam[BW-1] ^ w_bam[BW-2];
    assign w_bam_f = {w_bam[BW-1] ^ w_fold, w_bam[BW-2:0]};

    always_comb begin
        unique case (w_mode) inside
            axr3d_pkg::MODE_X: begin
                w_u = w_y;
                w_v = w_z;
            end
            axr3d_pkg::MODE_Y: begin
                w_u = w_z;
                w_v = w_x;
            end
            axr3d_pkg::MODE_Z, axr3d_pkg::MODE_NONE: begin
                w_u = w_x;
                w_v = w_y;
            end
            default: begin
                w_u = w_x;
                w_v = w_y;
            end
        endcase
    end

    // gain scaling works on magnitudes so that rounding is half away from zero
    assign w_mag_u = w_u[CW-1] ? unsigned'(-w_u) : unsigned'(w_u);
    assign w_mag_v = w_v[CW-1] ? unsigned'(-w_v) : unsigned'(w_v);

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    logic                   r1_vld;
    axr3d_pkg::t_side       r1_side;
    logic [CW-1:0]          r1_mag_u;
    logic [CW-1:0]          r1_mag_v;
    logic                   r1_neg_u;
    logic                   r1_neg_v;
    logic signed [ZW-1:0]   r1_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_side.mode <= w_mode;
            r1_side.x    <= w_x;
            r1_side.y    <= w_y;
            r1_side.z    <= w_z;
            r1_mag_u     <= w_mag_u;
            r1_mag_v     <= w_mag_v;
            r1_neg_u     <= w_u[CW-1] ^ w_fold;
            r1_neg_v     <= w_v[CW-1] ^ w_fold;
            r1_z         <= ZW'(signed'(w_bam_f));
        end
    end

    // ------------------------------------------------------------------
    // stage 2: magnitude times inverse gain
    // ------------------------------------------------------------------
    logic                   r2_vld;
    axr3d_pkg::t_side       r2_side;
    logic [PW-1:0]          r2_pu;
    logic [PW-1:0]          r2_pv;
    logic                   r2_neg_u;
    logic                   r2_neg_v;
    logic signed [ZW-1:0]   r2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_side  <= r1_side;
            r2_pu    <= PW'(r1_mag_u) * PW'(axr3d_pkg::INV_GAIN);
            r2_pv    <= PW'(r1_mag_v) * PW'(axr3d_pkg::INV_GAIN);
            r2_neg_u <= r1_neg_u;
            r2_neg_v <= r1_neg_v;
            r2_z     <= r1_z;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: round the product down to GUARD fraction bits
    // ------------------------------------------------------------------
    logic                   r3_vld;
    axr3d_pkg::t_side       r3_side;
    logic [SW-1:0]          r3_su;
    logic [SW-1:0]          r3_sv;
    logic                   r3_neg_u;
    logic                   r3_neg_v;
    logic signed [ZW-1:0]   r3_z;
    logic [PW-1:0]          w_rnd_u;
    logic [PW-1:0]          w_rnd_v;

    assign w_rnd_u = r2_pu + axr3d_pkg::SCL_RND;
    assign w_rnd_v = r2_pv + axr3d_pkg::SCL_RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_side  <= r2_side;
            r3_su    <= w_rnd_u[PW-1:SSH];
            r3_sv    <= w_rnd_v[PW-1:SSH];
            r3_neg_u <= r2_neg_u;
            r3_neg_v <= r2_neg_v;
            r3_z     <= r2_z;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: apply sign and fold, load the cordic head
    // ------------------------------------------------------------------
    logic signed [DW-1:0]   r_cx [0:NI];
    logic signed [DW-1:0]   r_cy [0:NI];
    logic signed [ZW-1:0]   r_cz [0:NI];
    axr3d_pkg::t_side       r_cside [0:NI];
    logic signed [DW-1:0]   w_ext_u;
    logic signed [DW-1:0]   w_ext_v;

    assign w_ext_u = signed'(DW'(r3_su));
    assign w_ext_v = signed'(DW'(r3_sv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld[0] <= 1'b0;
        end else if (w_adv) begin
            r_cvld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cside[0] <= r3_side;
            r_cx[0]    <= r3_neg_u ? -w_ext_u : w_ext_u;
            r_cy[0]    <= r3_neg_v ? -w_ext_v : w_ext_v;
            r_cz[0]    <= r3_z;
        end
    end

    // ------------------------------------------------------------------
    // cordic: one micro-rotation per stage, driving the residual angle to zero
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < NI; gi++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cvld[gi+1] <= 1'b0;
            end else if (w_adv) begin
                r_cvld[gi+1] <= r_cvld[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_cside[gi+1] <= r_cside[gi];
                if (!r_cz[gi][ZW-1]) begin
                    r_cx[gi+1] <= r_cx[gi] - (r_cy[gi] >>> gi);
                    r_cy[gi+1] <= r_cy[gi] + (r_cx[gi] >>> gi);
                    r_cz[gi+1] <= r_cz[gi] - signed'(ZW'(axr3d_pkg::ATAN_TAB[gi]));
                end else begin
                    r_cx[gi+1] <= r_cx[gi] + (r_cy[gi] >>> gi);
                    r_cy[gi+1] <= r_cy[gi] - (r_cx[gi] >>> gi);
                    r_cz[gi+1] <= r_cz[gi] + signed'(ZW'(axr3d_pkg::ATAN_TAB[gi]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: round, saturate, put the pair back on its axes
    // ------------------------------------------------------------------
    axr3d_pkg::t_sat            w_sat_u;
    axr3d_pkg::t_sat            w_sat_v;
    axr3d_pkg::t_side           w_tail;
    logic signed [CW-1:0]       w_ox;
    logic signed [CW-1:0]       w_oy;
    logic signed [CW-1:0]       w_oz;
    logic                       w_osat;

    logic signed [CW-1:0]       r_out_x;
    logic signed [CW-1:0]       r_out_y;
    logic signed [CW-1:0]       r_out_z;
    logic                       r_out_sat;
    axr3d_pkg::t_mode           r_out_mode;

    assign w_sat_u = axr3d_pkg::sat_coord(r_cx[NI]);
    assign w_sat_v = axr3d_pkg::sat_coord(r_cy[NI]);
    assign w_tail  = r_cside[NI];

    always_comb begin
        unique case (w_tail.mode) inside
            axr3d_pkg::MODE_X: begin
                w_ox   = w_tail.x;
                w_oy   = w_sat_u.val;
                w_oz   = w_sat_v.val;
                w_osat = w_sat_u.clip | w_sat_v.clip;
            end
            axr3d_pkg::MODE_Y: begin
                w_ox   = w_sat_v.val;
                w_oy   = w_tail.y;
                w_oz   = w_sat_u.val;
                w_osat = w_sat_u.clip | w_sat_v.clip;
            end
            axr3d_pkg::MODE_Z: begin
                w_ox   = w_sat_u.val;
                w_oy   = w_sat_v.val;
                w_oz   = w_tail.z;
                w_osat = w_sat_u.clip | w_sat_v.clip;
            end
            default: begin
                // unused mode: point passes through untouched
                w_ox   = w_tail.x;
                w_oy   = w_tail.y;
                w_oz   = w_tail.z;
                w_osat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= r_cvld[NI];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_x    <= w_ox;
            r_out_y    <= w_oy;
            r_out_z    <= w_oz;
            r_out_sat  <= w_osat;
            r_out_mode <= w_tail.mode;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = axr3d_pkg::OUT_DATA_W'({r_out_z, r_out_y, r_out_x});
    assign m_axis_tuser[0] = r_out_sat;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r1_vld)
        else $error("accepted word missing in first stage");

    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && r_cvld[NI]) |-> !s_axis_tready)
        else $error("input taken while pipeline must hold");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (r_out_x == axr3d_pkg::COORD_MAX || r_out_x == axr3d_pkg::COORD_MIN ||
             r_out_y == axr3d_pkg::COORD_MAX || r_out_y == axr3d_pkg::COORD_MIN ||
             r_out_z == axr3d_pkg::COORD_MAX || r_out_z == axr3d_pkg::COORD_MIN))
        else $error("saturated flag without a clipped coordinate");

    a_passthrough_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_mode == axr3d_pkg::MODE_NONE) |-> !m_axis_tuser[0])
        else $error("saturated flag on pass-through word");

endmodule
